// ===== rtl/cbet_pkg.sv =====
// ----------------------------------------------------------------------------
// cbet_pkg: shared types and constants for the control binding edge tracker
// Mode codes, table sizing, look limits and the token that walks the cell row.
// ----------------------------------------------------------------------------
package cbet_pkg;

	localparam int NUM_BINDINGS = 16;
	localparam int NUM_ACTIONS  = 32;
	localparam int CNT_W        = $clog2(NUM_BINDINGS + 1);

	// Item modes
	localparam logic [2:0] MODE_BIND       = 3'd0;
	localparam logic [2:0] MODE_BUTTON     = 3'd1;
	localparam logic [2:0] MODE_MOTION     = 3'd2;
	localparam logic [2:0] MODE_DISCONNECT = 3'd3;
	localparam logic [2:0] MODE_CLEAR      = 3'd4;
	localparam logic [2:0] MODE_TAKE       = 3'd5;

	// Look clamp, Q.12 of one million
	localparam logic signed [33:0] LOOK_MAX = 34'sd4096000000;
	localparam logic signed [33:0] LOOK_MIN = -34'sd4096000000;

	// Token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic        valid;
		logic [2:0]  mode;
		logic [3:0]  device;
		logic [15:0] code;
		logic [4:0]  action;
		logic        down;
		logic        found;
		logic        appended;
		logic [31:0] held;
	} cbet_tok_t;

endpackage

// ===== rtl/control_binding_edge_tracker_core.sv =====
// ----------------------------------------------------------------------------
// control_binding_edge_tracker_core: binding table with held/edge tracking
// A row of binding cells walked by one token per table item, plus the
// frame state (held, pressed, released, look sums) kept at the top.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | mode device code action down delta_x/y finite
//  out     | out_valid / out_ready| ok held_mask pressed_mask released_mask look_x/y_sum
//
//  Bind, button, disconnect and clear walk the cell row: the token passes
//  through every cell register before ST_DONE. Motion, take, out-of-range
//  binds and unused modes use ST_APPLY. One item is in work at a time; in_ready is
//  high only when idle. The output register holds a result until taken, and a
//  new item may be accepted meanwhile. Reset clears the down flags, count and frame.
// ----------------------------------------------------------------------------
module control_binding_edge_tracker_core import cbet_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [3:0]         device,
	input  logic [15:0]        code,
	input  logic [5:0]         action,
	input  logic               down,
	input  logic signed [32:0] delta_x,
	input  logic signed [32:0] delta_y,
	input  logic               finite,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [31:0]        held_mask,
	output logic [31:0]        pressed_mask,
	output logic [31:0]        released_mask,
	output logic signed [32:0] look_x_sum,
	output logic signed [32:0] look_y_sum
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        held_q, pressed_q, released_q;
	logic signed [32:0] look_x_q, look_y_q;

	// latched item
	logic [2:0]         mode_q;
	logic               act_bad_q;
	logic signed [32:0] dx_q, dy_q;
	logic               fin_q;

	// pending result
	logic               res_ok_q;
	logic [31:0]        res_held_q, res_pr_q, res_rl_q;
	logic signed [32:0] res_lx_q, res_ly_q;

	// output register
	logic               out_valid_q;
	logic               ok_q;
	logic [31:0]        held_out_q, pr_out_q, rl_out_q;
	logic signed [32:0] lx_out_q, ly_out_q;

	cbet_tok_t          launch_q;
	cbet_tok_t          tok [NUM_BINDINGS+1];

	logic               accept;
	logic               act_ok;
	logic               needs_walk;
	logic               tail_done;
	logic               recompute;
	logic [31:0]        h_new;
	logic signed [33:0] sum_x, sum_y;
	logic signed [32:0] clamp_x, clamp_y;
	logic               out_free;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign act_ok   = action < 6'(NUM_ACTIONS);
	assign needs_walk = (mode == MODE_BIND && act_ok) || mode == MODE_BUTTON ||
		mode == MODE_DISCONNECT || mode == MODE_CLEAR;
	assign tail_done = tok[NUM_BINDINGS].valid;
	assign out_free  = !out_valid_q || out_ready;

	// Cell row
	assign tok[0] = launch_q;
	for (genvar i = 0; i < NUM_BINDINGS; i++) begin : g_cell
		cbet_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.index  (CNT_W'(i)),
			.count  (count_q),
			.tok_i  (tok[i]),
			.tok_o  (tok[i+1])
		);
	end

	// Held recompute at the end of a walk; saturating look sums
	always_comb begin
		recompute = mode_q == MODE_BUTTON || mode_q == MODE_DISCONNECT ||
			(mode_q == MODE_BIND && tok[NUM_BINDINGS].found);
		h_new = recompute ? tok[NUM_BINDINGS].held : held_q;

		sum_x = 34'(look_x_q) + 34'(dx_q);
		sum_y = 34'(look_y_q) + 34'(dy_q);
		if (sum_x > LOOK_MAX) clamp_x = 33'(LOOK_MAX);
		else if (sum_x < LOOK_MIN) clamp_x = 33'(LOOK_MIN);
		else clamp_x = 33'(sum_x);
		if (sum_y > LOOK_MAX) clamp_y = 33'(LOOK_MAX);
		else if (sum_y < LOOK_MIN) clamp_y = 33'(LOOK_MIN);
		else clamp_y = 33'(sum_y);
	end

	// Latched item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode;
			act_bad_q <= mode == MODE_BIND && !act_ok;
			dx_q      <= delta_x;
			dy_q      <= delta_y;
			fin_q     <= finite;
		end
	end

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			held_q      <= '0;
			pressed_q   <= '0;
			released_q  <= '0;
			look_x_q    <= '0;
			look_y_q    <= '0;
			launch_q    <= '0;
			res_ok_q    <= 1'b0;
			res_held_q  <= '0;
			res_pr_q    <= '0;
			res_rl_q    <= '0;
			res_lx_q    <= '0;
			res_ly_q    <= '0;
			out_valid_q <= 1'b0;
			ok_q        <= 1'b0;
			held_out_q  <= '0;
			pr_out_q    <= '0;
			rl_out_q    <= '0;
			lx_out_q    <= '0;
			ly_out_q    <= '0;
		end else begin
			// token valid for one cycle; result beat drops once taken
			if (!accept) launch_q.valid <= 1'b0;
			if (state_q != ST_DONE && out_ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						launch_q.valid <= needs_walk;
						if (needs_walk) begin
							launch_q.mode     <= mode;
							launch_q.device   <= device;
							launch_q.code     <= code;
							launch_q.action   <= action[4:0];
							launch_q.down     <= down;
							launch_q.found    <= 1'b0;
							launch_q.appended <= 1'b0;
							launch_q.held     <= '0;
							state_q           <= ST_WALK;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_WALK: begin
					if (tail_done) begin
						if (mode_q == MODE_CLEAR) begin
							held_q     <= '0;
							pressed_q  <= '0;
							released_q <= '0;
							look_x_q   <= '0;
							look_y_q   <= '0;
							res_held_q <= '0;
							res_pr_q   <= '0;
							res_rl_q   <= '0;
							res_lx_q   <= '0;
							res_ly_q   <= '0;
							res_ok_q   <= 1'b1;
						end else begin
							held_q     <= h_new;
							pressed_q  <= pressed_q | (h_new & ~held_q);
							released_q <= released_q | (held_q & ~h_new);
							res_held_q <= h_new;
							res_pr_q   <= pressed_q | (h_new & ~held_q);
							res_rl_q   <= released_q | (held_q & ~h_new);
							res_lx_q   <= look_x_q;
							res_ly_q   <= look_y_q;
							res_ok_q   <= mode_q != MODE_BIND ||
								tok[NUM_BINDINGS].found || tok[NUM_BINDINGS].appended;
							if (mode_q == MODE_BIND && tok[NUM_BINDINGS].appended)
								count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_APPLY: begin
					res_ok_q   <= !act_bad_q;
					res_held_q <= held_q;
					res_pr_q   <= pressed_q;
					res_rl_q   <= released_q;
					if (mode_q == MODE_MOTION && fin_q) begin
						look_x_q <= clamp_x;
						look_y_q <= clamp_y;
						res_lx_q <= clamp_x;
						res_ly_q <= clamp_y;
					end else begin
						res_lx_q <= look_x_q;
						res_ly_q <= look_y_q;
					end
					if (mode_q == MODE_TAKE) begin
						pressed_q  <= '0;
						released_q <= '0;
						look_x_q   <= '0;
						look_y_q   <= '0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ok_q        <= res_ok_q;
						held_out_q  <= res_held_q;
						pr_out_q    <= res_pr_q;
						rl_out_q    <= res_rl_q;
						lx_out_q    <= res_lx_q;
						ly_out_q    <= res_ly_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign held_mask     = held_out_q;
	assign pressed_mask  = pr_out_q;
	assign released_mask = rl_out_q;
	assign look_x_sum    = lx_out_q;
	assign look_y_sum    = ly_out_q;

endmodule

// ===== rtl/cbet_cell.sv =====
// ----------------------------------------------------------------------------
// cbet_cell: one binding slot of the table
// Holds device, code, action and down flag; updates them as the token passes
// and adds its action bit to the token's running held mask.
// ----------------------------------------------------------------------------
module cbet_cell import cbet_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] index,
	input  logic [CNT_W-1:0] count,
	input  cbet_tok_t        tok_i,
	output cbet_tok_t        tok_o
);

	logic [3:0]  device_q;
	logic [15:0] code_q;
	logic [4:0]  action_q;
	logic        down_q;
	cbet_tok_t   tok_q;

	logic        used;
	logic        hit;
	logic        bind_hit;
	logic        append;
	logic        down_nx;
	logic [4:0]  action_nx;
	logic [31:0] contrib;
	cbet_tok_t   tok_nx;

	// Slot decode and next values
	always_comb begin
		used     = index < count;
		hit      = tok_i.valid && used && device_q == tok_i.device && code_q == tok_i.code;
		bind_hit = tok_i.mode == MODE_BIND && hit && !tok_i.found;
		append   = tok_i.valid && tok_i.mode == MODE_BIND && index == count && !tok_i.found;

		down_nx   = down_q;
		action_nx = action_q;
		if (tok_i.valid) begin
			case (tok_i.mode)
				MODE_BIND: begin
					if (bind_hit || append) action_nx = tok_i.action;
					if (append) down_nx = 1'b0;
				end
				MODE_BUTTON: begin
					if (hit) down_nx = tok_i.down;
				end
				MODE_DISCONNECT: begin
					if (used && device_q == tok_i.device) down_nx = 1'b0;
				end
				MODE_CLEAR: begin
					down_nx = 1'b0;
				end
				default: begin
				end
			endcase
		end

		contrib = (used && down_nx) ? (32'd1 << action_nx) : 32'd0;

		tok_nx          = tok_i;
		tok_nx.found    = tok_i.found | bind_hit;
		tok_nx.appended = tok_i.appended | append;
		tok_nx.held     = tok_i.held | contrib;
	end

	// Binding payload: device and code written on append, action on append or rebind
	always_ff @(posedge clk) begin
		if (append) begin
			device_q <= tok_i.device;
			code_q   <= tok_i.code;
		end
		action_q <= action_nx;
	end

	// Down flag and the token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= 1'b0;
			tok_q  <= '0;
		end else begin
			down_q <= down_nx;
			tok_q  <= tok_i.valid ? tok_nx : '0;
		end
	end

	assign tok_o = tok_q;

endmodule

// ===== rtl/cbet_checker.sv =====
// ----------------------------------------------------------------------------
// cbet_checker: port-level checks for the control binding edge tracker
// Watches the handshakes and the look clamp; bound onto the top level.
// ----------------------------------------------------------------------------
module cbet_checker import cbet_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               ok,
	input logic [31:0]        held_mask,
	input logic [31:0]        pressed_mask,
	input logic [31:0]        released_mask,
	input logic signed [32:0] look_x_sum,
	input logic signed [32:0] look_y_sum
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(held_mask) &&
			$stable(pressed_mask) && $stable(released_mask) &&
			$stable(look_x_sum) && $stable(look_y_sum))
		else $error("result beat changed while stalled");

	// one item in work: busy right after an input beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while previous item in work");

	// look sums never leave the clamp range
	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> look_x_sum <= 33'(LOOK_MAX) && look_x_sum >= 33'(LOOK_MIN))
		else $error("look_x_sum outside clamp");

	a_clamp_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> look_y_sum <= 33'(LOOK_MAX) && look_y_sum >= 33'(LOOK_MIN))
		else $error("look_y_sum outside clamp");

endmodule

bind control_binding_edge_tracker_core cbet_checker u_cbet_checker (.*);

// ===== verif/tb_control_binding_edge_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_control_binding_edge_tracker_core: self-checking bench for the tracker
// A directed pass fills the binding table and hits the corner cases: rejected
// and full-table binds, rebinding a held control, look saturation, ignored
// motion, disconnect, clear, take and the spare modes. A long random pass
// follows. A scoreboard class predicts every result beat and checks each one
// in order. Both handshakes idle at random, with one burst without gaps, one
// long output stall and three full drains.
// ----------------------------------------------------------------------------
module tb_control_binding_edge_tracker_core;
	import cbet_pkg::*;

	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         TAIL_CYCLES  = NUM_BINDINGS + 8;
	localparam int         RUN_LIMIT    = 5_000_000;

	// One input beat, as the ports see it
	typedef struct {
		logic [2:0]         mode;
		logic [3:0]         device;
		logic [15:0]        code;
		logic [5:0]         action;
		logic               down;
		logic signed [32:0] delta_x;
		logic signed [32:0] delta_y;
		logic               finite;
	} beat_t;

	// One result beat
	typedef struct {
		logic               ok;
		logic [31:0]        held;
		logic [31:0]        pressed;
		logic [31:0]        released;
		logic signed [32:0] look_x;
		logic signed [32:0] look_y;
	} frame_t;

	// Binding table and frame tracker; predicts frames and checks them in order
	class edge_scoreboard;
		logic [3:0]  tbl_dev  [NUM_BINDINGS];
		logic [15:0] tbl_code [NUM_BINDINGS];
		logic [4:0]  tbl_act  [NUM_BINDINGS];
		bit          tbl_down [NUM_BINDINGS];
		int          tbl_used;
		logic [31:0] held;
		logic [31:0] pressed;
		logic [31:0] released;
		longint      look_x;
		longint      look_y;
		frame_t      frames_due[$];
		int          errors;
		int          checked;
		int          binds_rejected;
		int          mode_seen [8];

		function new();
			tbl_used = 0;
			held = '0;
			pressed = '0;
			released = '0;
			look_x = 0;
			look_y = 0;
			errors = 0;
			checked = 0;
			binds_rejected = 0;
			foreach (tbl_down[i]) tbl_down[i] = 1'b0;
			foreach (mode_seen[i]) mode_seen[i] = 0;
		endfunction

		function longint clamp_look(longint v);
			if (v > longint'(LOOK_MAX)) return longint'(LOOK_MAX);
			if (v < longint'(LOOK_MIN)) return longint'(LOOK_MIN);
			return v;
		endfunction

		// held from the down bindings, edges folded into pressed/released
		function void refresh_held();
			logic [31:0] h;
			h = '0;
			for (int i = 0; i < tbl_used; i++)
				if (tbl_down[i]) h[tbl_act[i]] = 1'b1;
			pressed  |= h & ~held;
			released |= held & ~h;
			held = h;
		endfunction

		function void note_input(beat_t b);
			frame_t f;
			bit     hit;
			f.ok = 1'b1;
			hit = 1'b0;
			mode_seen[b.mode]++;
			case (b.mode)
			MODE_BIND: begin
				if (b.action >= NUM_ACTIONS) begin
					f.ok = 1'b0;
				end else begin
					for (int i = 0; i < tbl_used; i++)
						if (!hit && tbl_dev[i] == b.device && tbl_code[i] == b.code) begin
							tbl_act[i] = b.action[4:0];
							hit = 1'b1;
						end
					if (hit) begin
						refresh_held();
					end else if (tbl_used >= NUM_BINDINGS) begin
						f.ok = 1'b0;
					end else begin
						// fresh binding starts released, held unchanged
						tbl_dev[tbl_used]  = b.device;
						tbl_code[tbl_used] = b.code;
						tbl_act[tbl_used]  = b.action[4:0];
						tbl_down[tbl_used] = 1'b0;
						tbl_used++;
					end
				end
				if (!f.ok) binds_rejected++;
			end
			MODE_BUTTON: begin
				for (int i = 0; i < tbl_used; i++)
					if (tbl_dev[i] == b.device && tbl_code[i] == b.code) tbl_down[i] = b.down;
				refresh_held();
			end
			MODE_MOTION: begin
				if (b.finite) begin
					look_x = clamp_look(look_x + longint'(b.delta_x));
					look_y = clamp_look(look_y + longint'(b.delta_y));
				end
			end
			MODE_DISCONNECT: begin
				for (int i = 0; i < tbl_used; i++)
					if (tbl_dev[i] == b.device) tbl_down[i] = 1'b0;
				refresh_held();
			end
			MODE_CLEAR: begin
				// no edges recorded here
				for (int i = 0; i < tbl_used; i++) tbl_down[i] = 1'b0;
				held = '0;
				pressed = '0;
				released = '0;
				look_x = 0;
				look_y = 0;
			end
			default: ;
			endcase

			f.held     = held;
			f.pressed  = pressed;
			f.released = released;
			f.look_x   = look_x[32:0];
			f.look_y   = look_y[32:0];
			// take reports the frame, then zeroes it; held and bindings stay
			if (b.mode == MODE_TAKE) begin
				pressed = '0;
				released = '0;
				look_x = 0;
				look_y = 0;
			end
			frames_due.push_back(f);
		endfunction

		function void compare_field(string name, logic signed [63:0] e, logic signed [63:0] a);
			if (e !== a) begin
				$display("%0t mismatch on %s: expected %0d (0x%0h) actual %0d (0x%0h)",
					$time, name, e, e, a, a);
				errors++;
			end
		endfunction

		function void check_result(frame_t r);
			frame_t e;
			if (frames_due.size() == 0) begin
				$display("%0t result beat with nothing outstanding", $time);
				errors++;
				return;
			end
			e = frames_due.pop_front();
			checked++;
			compare_field("ok", e.ok, r.ok);
			compare_field("held_mask", e.held, r.held);
			compare_field("pressed_mask", e.pressed, r.pressed);
			compare_field("released_mask", e.released, r.released);
			compare_field("look_x_sum", e.look_x, r.look_x);
			compare_field("look_y_sum", e.look_y, r.look_y);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         mode;
	logic [3:0]         device;
	logic [15:0]        code;
	logic [5:0]         action;
	logic               down;
	logic signed [32:0] delta_x;
	logic signed [32:0] delta_y;
	logic               finite;
	logic               out_valid;
	logic               out_ready;
	logic               ok;
	logic [31:0]        held_mask;
	logic [31:0]        pressed_mask;
	logic [31:0]        released_mask;
	logic signed [32:0] look_x_sum;
	logic signed [32:0] look_y_sum;

	edge_scoreboard sb = new();

	int          send_idle_pct = 13;
	int          recv_idle_pct = 13;
	int          hold_asks = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	logic [3:0]  pool_dev  [NUM_BINDINGS];
	logic [15:0] pool_code [NUM_BINDINGS];

	control_binding_edge_tracker_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.device        (device),
		.code          (code),
		.action        (action),
		.down          (down),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.finite        (finite),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.held_mask     (held_mask),
		.pressed_mask  (pressed_mask),
		.released_mask (released_mask),
		.look_x_sum    (look_x_sum),
		.look_y_sum    (look_y_sum)
	);

	// Clock, period 10
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Beat with every field random; callers override what the mode uses
	function automatic beat_t noisy_beat(logic [2:0] m);
		beat_t b;
		b.mode    = m;
		b.device  = 4'($urandom);
		b.code    = 16'($urandom);
		b.action  = 6'($urandom);
		b.down    = 1'($urandom);
		b.delta_x = {1'($urandom), 32'($urandom)};
		b.delta_y = {1'($urandom), 32'($urandom)};
		b.finite  = 1'($urandom);
		return b;
	endfunction

	// Deltas: small, medium, full 33-bit, exact limit, 33-bit extremes
	function automatic logic signed [32:0] pick_delta();
		logic signed [32:0] d;
		case ($urandom_range(0, 5))
		0:       d = 33'($urandom_range(0, 8191)) - 33'd4096;
		1:       d = {1'($urandom), 32'($urandom)};
		2:       d = $urandom_range(0, 1) ? 33'(LOOK_MAX) : 33'(LOOK_MIN);
		3:       d = $urandom_range(0, 1) ? 33'sh0_FFFF_FFFF : 33'sh1_0000_0000;
		4:       d = 33'($signed(24'($urandom)));
		default: d = 33'($signed(30'($urandom)));
		endcase
		return d;
	endfunction

	// Mostly legal actions, some out of range
	function automatic logic [5:0] pick_action();
		if ($urandom_range(0, 4) == 0) return 6'($urandom_range(NUM_ACTIONS, 63));
		return 6'($urandom_range(0, NUM_ACTIONS - 1));
	endfunction

	// Offer one beat at the falling edge, hold it until accepted
	task automatic send_beat(beat_t b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode     = b.mode;
		device   = b.device;
		code     = b.code;
		action   = b.action;
		down     = b.down;
		delta_x  = b.delta_x;
		delta_y  = b.delta_y;
		finite   = b.finite;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(b);
	endtask

	task automatic do_bind(logic [3:0] dev, logic [15:0] cd, logic [5:0] act);
		beat_t b;
		b = noisy_beat(MODE_BIND);
		b.device = dev;
		b.code   = cd;
		b.action = act;
		send_beat(b);
	endtask

	task automatic do_button(logic [3:0] dev, logic [15:0] cd, logic dn);
		beat_t b;
		b = noisy_beat(MODE_BUTTON);
		b.device = dev;
		b.code   = cd;
		b.down   = dn;
		send_beat(b);
	endtask

	task automatic do_motion(logic signed [32:0] dx, logic signed [32:0] dy, logic fin);
		beat_t b;
		b = noisy_beat(MODE_MOTION);
		b.delta_x = dx;
		b.delta_y = dy;
		b.finite  = fin;
		send_beat(b);
	endtask

	task automatic do_mode(logic [2:0] m, logic [3:0] dev);
		beat_t b;
		b = noisy_beat(m);
		b.device = dev;
		send_beat(b);
	endtask

	// Stop offering, wait for every outstanding frame, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.frames_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Random traffic, mostly aimed at the bound controls
	task automatic random_item();
		int pick;
		int slot;
		pick = $urandom_range(0, 99);
		slot = $urandom_range(0, NUM_BINDINGS - 1);
		if (pick < 15) begin
			if ($urandom_range(0, 9) < 7) do_bind(pool_dev[slot], pool_code[slot], pick_action());
			else do_bind(4'($urandom), 16'($urandom), pick_action());
		end else if (pick < 55) begin
			if ($urandom_range(0, 99) < 85) do_button(pool_dev[slot], pool_code[slot], 1'($urandom));
			else do_button(4'($urandom), 16'($urandom), 1'($urandom));
		end else if (pick < 75) begin
			do_motion(pick_delta(), pick_delta(), $urandom_range(0, 9) != 0);
		end else if (pick < 82) begin
			do_mode(MODE_DISCONNECT, ($urandom_range(0, 4) == 0) ? 4'($urandom) : pool_dev[slot]);
		end else if (pick < 86) begin
			do_mode(MODE_CLEAR, 4'($urandom));
		end else if (pick < 98) begin
			do_mode(MODE_TAKE, 4'($urandom));
		end else begin
			do_mode($urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7, 4'($urandom));
		end
	endtask

	// Result side: check at the rising edge, decide ready at the falling edge
	initial begin
		frame_t r;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				r.ok       = ok;
				r.held     = held_mask;
				r.pressed  = pressed_mask;
				r.released = released_mask;
				r.look_x   = look_x_sum;
				r.look_y   = look_y_sum;
				sb.check_result(r);
			end
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog
	initial begin
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus
	initial begin
		in_valid = 1'b0;
		mode     = MODE_TAKE;
		device   = '0;
		code     = '0;
		action   = '0;
		down     = 1'b0;
		delta_x  = '0;
		delta_y  = '0;
		finite   = 1'b0;
		arst_n   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty frame, button with nothing bound, out-of-range actions
		do_mode(MODE_TAKE, 4'd0);
		do_button(4'd3, 16'h1234, 1'b1);
		do_bind(4'd5, 16'h0055, 6'(NUM_ACTIONS));
		do_bind(4'd5, 16'h0055, 6'd63);

		// fill the table; entries 2 and 3 share an action
		for (int i = 0; i < NUM_BINDINGS; i++) begin
			if (i == 0) begin
				pool_dev[i]  = 4'd0;
				pool_code[i] = 16'h0000;
			end else if (i == 1) begin
				pool_dev[i]  = 4'd15;
				pool_code[i] = 16'hFFFF;
			end else begin
				pool_dev[i]  = 4'(i % 5);
				pool_code[i] = {4'(i), 12'($urandom)};
			end
			do_bind(pool_dev[i], pool_code[i],
				(i == 0) ? 6'd0 : (i == 1) ? 6'(NUM_ACTIONS - 1) :
				(i < 4) ? 6'd7 : 6'($urandom_range(0, NUM_ACTIONS - 1)));
		end
		// new control with the table full
		do_bind(4'd9, 16'hBEEF, 6'd3);

		// press, then rebind a held control to move its action bit
		do_button(pool_dev[1], pool_code[1], 1'b1);
		do_button(pool_dev[0], pool_code[0], 1'b1);
		do_bind(pool_dev[1], pool_code[1], 6'd5);
		// shared action stays held while one of two is down
		do_button(pool_dev[2], pool_code[2], 1'b1);
		do_button(pool_dev[3], pool_code[3], 1'b1);
		do_button(pool_dev[2], pool_code[2], 1'b0);

		// look saturation both ways, ignored motion
		do_motion(33'(LOOK_MAX), 33'(LOOK_MIN), 1'b1);
		do_motion(33'sd1000, -33'sd1000, 1'b1);
		do_motion(33'sh1_0000_0000, 33'sh0_FFFF_FFFF, 1'b0);
		do_motion(33'sh1_0000_0000, 33'sh0_FFFF_FFFF, 1'b1);
		do_mode(MODE_TAKE, 4'd0);

		do_mode(MODE_DISCONNECT, 4'd0);
		do_mode(MODE_SPARE_6, 4'd0);
		do_mode(MODE_SPARE_7, 4'd15);
		do_mode(MODE_CLEAR, 4'd0);
		do_mode(MODE_TAKE, 4'd0);
		drain();

		// random, normal idling
		repeat (500) random_item();
		drain();

		// random, no gaps on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (400) random_item();

		// long output stall while beats keep coming, then idling again
		send_idle_pct = 13;
		recv_idle_pct = 13;
		hold_asks++;
		repeat (550) random_item();
		drain();

		$display("covered %0d beats: %0d binds (%0d rejected), %0d buttons, %0d motions, %0d takes",
			sb.checked, sb.mode_seen[MODE_BIND], sb.binds_rejected, sb.mode_seen[MODE_BUTTON],
			sb.mode_seen[MODE_MOTION], sb.mode_seen[MODE_TAKE]);
		$display("plus %0d disconnects, %0d clears, %0d spare-mode beats, %0d mismatches",
			sb.mode_seen[MODE_DISCONNECT], sb.mode_seen[MODE_CLEAR],
			sb.mode_seen[MODE_SPARE_6] + sb.mode_seen[MODE_SPARE_7], sb.errors);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cbet_pkg.sv
rtl/cbet_cell.sv
rtl/control_binding_edge_tracker_core.sv
rtl/cbet_checker.sv
verif/tb_control_binding_edge_tracker_core.sv
